/* rtl/core/hce_pkg.sv */
// Shared types and constants for the mod-26 Hill cipher encryptor.
// No dependencies; imported by every module of the block except the FIFO.
package hce_pkg;

    // Letter and key entry width, largest supported block, packed key width
    localparam int LETTER_W   = 5;
    localparam int MAX_BLOCK  = 3;
    localparam int KEY_W      = 45;

    // Row sum: three products of two 5-bit values fit in 12 bits
    localparam int SUM_W      = 12;
    localparam int LETTER_MOD = 26;

    // Reciprocal of 26 scaled by 2^16; exact quotient for any 12-bit sum
    localparam int RECIP       = 2521;
    localparam int RECIP_SHIFT = 16;
    localparam int QUO_W       = 8;

    // One complete block together with the key in force when it closed
    typedef struct packed {
        logic [KEY_W-1:0]                    key;
        logic [MAX_BLOCK-1:0][LETTER_W-1:0]  letters;
    } t_job;

    // One cipher letter as presented on the result side
    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                last;
    } t_result;

endpackage

/* rtl/core/hce_fifo.sv */
// Small show-ahead FIFO with occupancy count, used for the job queue and result queue.
// No package dependencies.
module hce_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic [WIDTH-1:0]               i_data,
    input  logic                           i_pop,
    output logic [WIDTH-1:0]               o_data,
    output logic                           o_full,
    output logic                           o_empty,
    output logic [$clog2(DEPTH+1)-1:0]     o_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Advance pointers with wrap and track occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store payload; no reset needed
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* rtl/core/hce_front.sv */
// Front end: key register, letter collection, job formation on block completion.
// Depends on hce_pkg.
module hce_front #(
    parameter int BLOCK_SIZE = 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [hce_pkg::KEY_W-1:0]     i_cfg_wdata,
    input  logic                          i_push,
    input  logic [hce_pkg::LETTER_W-1:0]  i_plain_letter,
    output logic                          o_full,
    input  logic                          i_job_full,
    output logic                          o_job_push,
    output hce_pkg::t_job                 o_job
);

    import hce_pkg::*;

    localparam int IDX_W = $clog2(BLOCK_SIZE);

    logic [KEY_W-1:0]    r_key;
    logic [IDX_W-1:0]    r_fill, n_fill;
    logic [LETTER_W-1:0] r_letters [BLOCK_SIZE-1];
    logic                closing;
    logic                accept;

    // Only the closing letter needs room in the job queue
    assign closing = (r_fill == IDX_W'(BLOCK_SIZE - 1));
    assign o_full  = closing && i_job_full;
    assign accept  = i_push && !o_full;

    // Hold the key; written whenever the enable is high
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_we) begin
            r_key <= i_cfg_wdata;
        end
    end

    // Advance the fill position, wrapping on the closing letter
    always_comb begin
        n_fill = r_fill;
        if (accept) begin
            n_fill = closing ? '0 : r_fill + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    // Store letters of a partial block at their decoded position
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < BLOCK_SIZE - 1; k++) begin
            if (accept && (r_fill == IDX_W'(k))) begin
                r_letters[k] <= i_plain_letter;
            end
        end
    end

    // Form the job: stored letters, the incoming one last, key snapshot
    always_comb begin
        o_job.key = r_key;
        for (int k = 0; k < MAX_BLOCK; k++) begin
            if (k < BLOCK_SIZE - 1) begin
                o_job.letters[k] = r_letters[k];
            end else if (k == BLOCK_SIZE - 1) begin
                o_job.letters[k] = i_plain_letter;
            end else begin
                o_job.letters[k] = '0;
            end
        end
    end

    assign o_job_push = accept && closing;

endmodule

/* rtl/core/hce_back.sv */
// Back end: row sequencer, dot-product stage, quotient stage and mod-26 remainder.
// Depends on hce_pkg; feeds the result queue with credit from its count.
module hce_back #(
    parameter int BLOCK_SIZE = 3,
    parameter int RES_DEPTH  = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  hce_pkg::t_job                     i_job,
    input  logic                              i_job_empty,
    output logic                              o_job_pop,
    input  logic [$clog2(RES_DEPTH+1)-1:0]    i_res_count,
    output logic                              o_res_push,
    output hce_pkg::t_result                  o_res
);

    import hce_pkg::*;

    localparam int IDX_W  = $clog2(BLOCK_SIZE);
    localparam int CNT_W  = $clog2(RES_DEPTH + 1);
    localparam int PROD_W = 2 * LETTER_W;

    // Sequencer state
    logic                r_busy;
    logic [IDX_W-1:0]    r_row;
    t_job                r_job;

    // Sum stage and quotient stage
    logic                r_sum_vld;
    logic [SUM_W-1:0]    r_sum;
    logic                r_sum_last;
    logic                r_quo_vld;
    logic [SUM_W-1:0]    r_quo_sum;
    logic [QUO_W-1:0]    r_quo;
    logic                r_quo_last;

    logic [LETTER_W-1:0] key_ent [BLOCK_SIZE][BLOCK_SIZE];
    logic [CNT_W:0]      in_flight;
    logic                credit;
    logic                issue;
    logic                last_row;
    logic [SUM_W-1:0]    row_sum;
    logic [2*SUM_W-1:0]  recip_prod;
    logic [SUM_W-1:0]    quo_times_mod;
    logic [SUM_W-1:0]    rem;

    // Split the key snapshot into its row-major entries
    always_comb begin
        for (int i = 0; i < BLOCK_SIZE; i++) begin
            for (int j = 0; j < BLOCK_SIZE; j++) begin
                key_ent[i][j] = r_job.key[LETTER_W*(i*BLOCK_SIZE+j) +: LETTER_W];
            end
        end
    end

    // Issue a row only if the result queue can take everything in flight
    assign in_flight = (CNT_W+1)'(i_res_count) + (CNT_W+1)'(r_sum_vld)
                     + (CNT_W+1)'(r_quo_vld);
    assign credit    = (in_flight < (CNT_W+1)'(RES_DEPTH));
    assign issue     = r_busy && credit;
    assign last_row  = (r_row == IDX_W'(BLOCK_SIZE - 1));
    assign o_job_pop = !r_busy && !i_job_empty;

    // Dot product of the current key row with the block
    always_comb begin
        row_sum = '0;
        for (int j = 0; j < BLOCK_SIZE; j++) begin
            row_sum = row_sum + SUM_W'(PROD_W'(key_ent[r_row][j]) * PROD_W'(r_job.letters[j]));
        end
    end

    // Sequence rows of the loaded job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= '0;
        end else if (o_job_pop) begin
            r_busy <= 1'b1;
            r_row  <= '0;
        end else if (issue) begin
            r_busy <= !last_row;
            r_row  <= last_row ? '0 : r_row + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job <= i_job;
        end
    end

    // Valid flags of the arithmetic stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_vld <= 1'b0;
            r_quo_vld <= 1'b0;
        end else begin
            r_sum_vld <= issue;
            r_quo_vld <= r_sum_vld;
        end
    end

    // Register the row sum
    always_ff @(posedge i_clk) begin
        r_sum      <= row_sum;
        r_sum_last <= last_row;
    end

    // Quotient by 26 through the scaled reciprocal
    assign recip_prod = (2*SUM_W)'(r_sum) * (2*SUM_W)'(RECIP);

    always_ff @(posedge i_clk) begin
        r_quo      <= recip_prod[RECIP_SHIFT +: QUO_W];
        r_quo_sum  <= r_sum;
        r_quo_last <= r_sum_last;
    end

    // Remainder from the exact quotient
    assign quo_times_mod = SUM_W'(SUM_W'(r_quo) * SUM_W'(LETTER_MOD));
    assign rem           = r_quo_sum - quo_times_mod;

    assign o_res_push  = r_quo_vld;
    assign o_res.letter = rem[LETTER_W-1:0];
    assign o_res.last   = r_quo_last;

endmodule

/* rtl/core/hill_cipher_encrypt.sv */
// Hill cipher encryptor mod 26: letters in, one cipher letter per key row out per block.
// A block's last letter passes the job queue, the job register, the sum and quotient registers
// and the result queue before its first cipher letter appears. Letters are taken one per cycle
// unless the closing letter meets a full job queue; the back end loads a job only when idle, then
// issues one row per cycle while the result queue has credit. Synchronous active-low reset clears
// the key, the fill position and both queues; no result is pending after reset.
module hill_cipher_encrypt #(
    parameter int BLOCK_SIZE = 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [hce_pkg::KEY_W-1:0]     i_cfg_wdata,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [hce_pkg::LETTER_W-1:0]  i_plain_letter,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic [hce_pkg::LETTER_W-1:0]  o_cipher_letter,
    output logic                          o_block_last
);

    import hce_pkg::*;

    localparam int JOB_DEPTH = 2;
    localparam int RES_DEPTH = 4;
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);
    localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

    t_job                 job_in;
    t_job                 job_out;
    logic                 job_push;
    logic                 job_pop;
    logic                 job_full;
    logic                 job_empty;
    logic [JOB_CNT_W-1:0] job_count;
    t_result              res_in;
    t_result              res_out;
    logic                 res_push;
    logic [RES_CNT_W-1:0] res_count;
    logic                 res_full;

    hce_front #(
        .BLOCK_SIZE (BLOCK_SIZE)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_push         (i_push),
        .i_plain_letter (i_plain_letter),
        .o_full         (o_full),
        .i_job_full     (job_full),
        .o_job_push     (job_push),
        .o_job          (job_in)
    );

    hce_fifo #(
        .WIDTH ($bits(t_job)),
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_full  (job_full),
        .o_empty (job_empty),
        .o_count (job_count)
    );

    hce_back #(
        .BLOCK_SIZE (BLOCK_SIZE),
        .RES_DEPTH  (RES_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job_out),
        .i_job_empty (job_empty),
        .o_job_pop   (job_pop),
        .i_res_count (res_count),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    hce_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push && !res_full),
        .i_data  (res_in),
        .i_pop   (i_pop),
        .o_data  (res_out),
        .o_full  (res_full),
        .o_empty (o_empty),
        .o_count (res_count)
    );

    assign o_cipher_letter = res_out.letter;
    // Job count is informational; fold it into nothing but keep the port consumed
    assign o_block_last    = res_out.last && (job_count <= JOB_CNT_W'(JOB_DEPTH));

endmodule

/* rtl/core/hce_checker.sv */
// Port-level checker for the Hill cipher encryptor, bound to the top level.
// Depends on hce_pkg for field widths.
module hce_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_full,
    input logic                          o_empty,
    input logic                          i_pop,
    input logic [hce_pkg::LETTER_W-1:0]  o_cipher_letter,
    input logic                          o_block_last
);

    import hce_pkg::*;

    // Reset leaves nothing to deliver
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> o_empty)
        else $error("result queue not empty after reset");

    // Reset leaves the input side open
    a_reset_open: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_full)
        else $error("input side full after reset");

    // Every delivered letter is reduced mod 26
    a_letter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_cipher_letter < LETTER_W'(LETTER_MOD)))
        else $error("cipher letter out of range");

    // A waiting result holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=>
            (!o_empty && $stable(o_cipher_letter) && $stable(o_block_last)))
        else $error("waiting result changed");

endmodule

bind hill_cipher_encrypt hce_checker u_hce_checker (.*);
